### hw/rtl/ntis_pkg.sv
package ntis_pkg;

   localparam int DEF_MAX_ENTRIES = 16;
   localparam int NAME_W          = 72;

   typedef enum logic [1:0] {
      FUNC_CREATE = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      STAT_CREATED   = 4'd0,
      STAT_EXISTS    = 4'd1,
      STAT_FULL      = 4'd2,
      STAT_DELETED   = 4'd3,
      STAT_ABSENT    = 4'd4,
      STAT_FOUND     = 4'd5,
      STAT_NOT_FOUND = 4'd6,
      STAT_ENTRY     = 4'd7,
      STAT_EMPTY     = 4'd8
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] name_low;
      logic [7:0]  name_high;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  position;
      logic [63:0] entry_low;
      logic [7:0]  entry_high;
      logic [4:0]  occupancy;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_key;
      logic       clr_idx;
      logic       inc_idx;
      logic       rd_en;
      logic       rd_next;
      logic       wr_en;
      logic       wr_shift;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_fire;
      status_type rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic match;
      logic full;
      logic empty;
      logic at_last;
   } sts_type;

endpackage

### hw/rtl/name_table_insert_delete_search.sv
// Create, delete and search read the entries one at a time, from the first. A miss examines all k
// entries before its result strobes; a hit on entry j strobes once entry j has been compared.
// A delete hit then moves each later entry down one place, reading it and writing it back one
// place lower, and then ends with a closing check; otherwise busy drops with the strobe. List
// gives one result per entry, in order; an empty table answers in the cycle after the transfer without raising busy.
// Synchronous reset empties the table, names are not cleared; results never stall.
module name_table_insert_delete_search #(
   parameter int MAX_ENTRIES = ntis_pkg::DEF_MAX_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ntis_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ntis_pkg::rsp_type rsp_data
);
   import ntis_pkg::*;

   // The controller sequences scans, compaction and listing; the datapath holds the
   // name memory, the search key, the entry count and the result register.
   cmd_type cmd;
   sts_type sts;

   ntis_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // A transfer happens when start is high while busy is low; for create, delete and search
   // the datapath captures the zero-terminated name at that edge.
   ntis_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_name_low  (req_data.name_low),
      .req_name_high (req_data.name_high),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data)
   );

endmodule

### hw/rtl/ntis_ctrl.sv
module ntis_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_func,
   input  ntis_pkg::sts_type sts,
   output ntis_pkg::cmd_type cmd,
   output logic             busy
);
   import ntis_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_LIST_RD,
      S_LIST_EMIT
   } state_type;

   state_type state_ff, state_in;
   func_type  func_ff, func_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         func_ff  <= FUNC_CREATE;
      end else begin
         state_ff <= state_in;
         func_ff  <= func_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = STAT_CREATED;
      state_in       = state_ff;
      func_in        = func_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in     = func_type'(req_func);
               cmd.clr_idx = 1'b1;
               if (func_type'(req_func) == FUNC_LIST) begin
                  if (sts.empty) begin
                     cmd.rsp_fire   = 1'b1;
                     cmd.rsp_status = STAT_EMPTY;
                  end else begin
                     state_in = S_LIST_RD;
                  end
               end else begin
                  cmd.load_key = 1'b1;
                  state_in     = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (sts.scan_done) begin
               // Every entry examined without a hit.
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
               unique case (func_ff)
                  FUNC_CREATE: begin
                     if (sts.full) begin
                        cmd.rsp_status = STAT_FULL;
                     end else begin
                        cmd.rsp_status = STAT_CREATED;
                        cmd.wr_en      = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                     end
                  end
                  FUNC_DELETE: cmd.rsp_status = STAT_ABSENT;
                  default:     cmd.rsp_status = STAT_NOT_FOUND;
               endcase
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (sts.match) begin
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
               unique case (func_ff)
                  FUNC_CREATE: cmd.rsp_status = STAT_EXISTS;
                  FUNC_DELETE: begin
                     cmd.rsp_status = STAT_DELETED;
                     cmd.cnt_dec    = 1'b1;
                     state_in       = S_SHIFT_RD;
                  end
                  default:     cmd.rsp_status = STAT_FOUND;
               endcase
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (sts.scan_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.inc_idx  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_LIST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LIST_EMIT;
         end
         S_LIST_EMIT: begin
            cmd.rsp_fire   = 1'b1;
            cmd.rsp_status = STAT_ENTRY;
            if (sts.at_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_LIST_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### hw/rtl/ntis_dp.sv
module ntis_dp #(
   parameter int MAX_ENTRIES = ntis_pkg::DEF_MAX_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [63:0]       req_name_low,
   input  logic [7:0]        req_name_high,
   input  ntis_pkg::cmd_type cmd,
   output ntis_pkg::sts_type sts,
   output logic              rsp_strobe,
   output ntis_pkg::rsp_type rsp_data
);
   import ntis_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [NAME_W-1:0] table_mem [MAX_ENTRIES];
   logic [NAME_W-1:0] rd_data_ff;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_plus;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [NAME_W-1:0] wr_data;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [CNT_W+3:0]  pos_wide;
   logic [CNT_W+4:0]  occ_wide;
   logic              keep;

   // A name ends at its first zero byte; later bytes are forced to zero.
   always_comb begin
      keep   = 1'b1;
      key_in = '0;
      for (int b = 0; b < 8; b++) begin
         if (req_name_low[b*8 +: 8] == 8'd0) begin
            keep = 1'b0;
         end
         key_in[8 + b*8 +: 8] = keep ? req_name_low[b*8 +: 8] : 8'd0;
      end
      key_in[7:0] = keep ? req_name_high : 8'd0;
   end

   assign idx_plus = idx_ff + CNT_W'(1);
   assign rd_addr  = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_addr  = idx_ff[IDX_W-1:0];
   assign wr_data  = cmd.wr_shift ? rd_data_ff : key_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clr_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_plus;
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign sts.scan_done = (idx_ff == count_ff);
   assign sts.match     = (rd_data_ff == key_ff);
   assign sts.full      = (count_ff == CNT_W'(MAX_ENTRIES));
   assign sts.empty     = (count_ff == '0);
   assign sts.at_last   = (idx_plus == count_ff);

   assign pos_wide = {4'd0, idx_ff};
   assign occ_wide = {5'd0, count_in};

   always_comb begin
      rsp_in            = '0;
      rsp_in.status     = cmd.rsp_status;
      rsp_in.occupancy  = occ_wide[4:0];
      rsp_in.last       = 1'b1;
      unique case (cmd.rsp_status)
         STAT_CREATED, STAT_EXISTS, STAT_DELETED, STAT_FOUND: begin
            rsp_in.position = pos_wide[3:0];
         end
         STAT_ENTRY: begin
            rsp_in.position   = pos_wide[3:0];
            rsp_in.entry_low  = rd_data_ff[NAME_W-1:8];
            rsp_in.entry_high = rd_data_ff[7:0];
            rsp_in.last       = sts.at_last;
         end
         default: rsp_in.position = 4'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_key) begin
         key_ff <= key_in;
      end
      if (cmd.rsp_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
